>>> rtl/palette_sprite_scaler_macros.svh
// Assertion macros for the palette sprite scaler.
`ifndef PALETTE_SPRITE_SCALER_MACROS_SVH
`define PALETTE_SPRITE_SCALER_MACROS_SVH

// Clocked on clk, disabled while rst is high.
`define PSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked on clk, also checked across reset.
`define PSS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/pss_pkg.sv
// Shared types and constants for the palette sprite scaler.
`default_nettype none
package pss_pkg;

  localparam int unsigned FRAC_BITS    = 16;
  localparam int unsigned PALETTE_SIZE = 256;
  localparam int unsigned PAL_AW       = 8;
  localparam int unsigned SIZE_W       = 7;
  localparam int unsigned ORIGIN_W     = 12;
  localparam int unsigned CFG_DATA_W   = 12;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned COORD_W      = 13;
  localparam int unsigned ROW_W        = 6;
  localparam int unsigned INDEX_W      = 12;
  localparam int unsigned COLOR_W      = 8;
  localparam int unsigned ACTION_W     = 2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

  localparam logic [ACTION_W-1:0] ACT_LOAD_PIXEL   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_LOAD_PALETTE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_DRAW         = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SKIP_ZERO  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y   = 3'd6;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [INDEX_W-1:0]  index;
    logic [COLOR_W-1:0]  value;
    logic [ROW_W-1:0]    row;
  } pss_cmd_t;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [COLOR_W-1:0] color;
    logic               write_enable;
    logic               last;
  } pss_pixel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SROW,
    ST_BASE,
    ST_RUN,
    ST_DRAIN
  } pss_state_t;

endpackage
`default_nettype wire

>>> rtl/pss_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module pss_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/pss_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module pss_div #(
  parameter int unsigned DVD_W = 23,
  parameter int unsigned DVS_W = 7
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int unsigned CNT_W = $clog2(DVD_W);

  logic             running;
  logic [CNT_W-1:0] count;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             fits;

  assign trial = {rem, quotient[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        count   <= '0;
      end else if (running) begin
        count <= count + CNT_W'(1);
        if (count == CNT_W'(DVD_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (running) begin
      rem      <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quotient <= {quotient[DVD_W-2:0], fits};
    end
  end

endmodule
`default_nettype wire

>>> rtl/palette_sprite_scaler.sv
// Top level of the nearest-neighbor palette sprite scaler.
//
// channel | dir | handshake                     | beat
// cmd     | in  | start high, busy low          | pss_cmd_t
// pixel   | out | pixel_valid, no back-pressure | pss_pixel_t
// cfg     | in  | cfg_we, cfg_index, cfg_data   | register write
//
// Loads, action 3 and a row at or past dst_height never raise busy.
// A draw runs both dividers (ST_DIV), the row and base multiplies (ST_SROW,
// ST_BASE), then one read per column (ST_RUN) through three pipeline stages;
// busy drops in the cycle that the last pixel shows; pixels cannot be stalled.
// Reset sets the sizes to 64 and the rest to 0; memories are undefined until loaded.
`default_nettype none
module palette_sprite_scaler
  import pss_pkg::*;
#(
  parameter int unsigned MAX_SIDE = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  pss_cmd_t              cmd,
  output logic                  pixel_valid,
  output pss_pixel_t            pixel,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int unsigned DEPTH  = MAX_SIDE * MAX_SIDE;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned QUO_W  = SIDE_W + FRAC_BITS;
  localparam int unsigned PROD_W = ROW_W + QUO_W;
  localparam int unsigned BASE_W = 2 * SIDE_W;

  function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIZE_W-1:0] v);
    logic [SIDE_W-1:0] r;
    if (v == '0) begin
      r = SIDE_W'(1);
    end else if (32'(v) > 32'(MAX_SIDE)) begin
      r = SIDE_W'(MAX_SIDE);
    end else begin
      r = SIDE_W'(v);
    end
    return r;
  endfunction

  logic [SIZE_W-1:0]   src_width;
  logic [SIZE_W-1:0]   src_height;
  logic [SIZE_W-1:0]   dst_width;
  logic [SIZE_W-1:0]   dst_height;
  logic                skip_zero;
  logic [ORIGIN_W-1:0] origin_x;
  logic [ORIGIN_W-1:0] origin_y;

  logic [SIDE_W-1:0] sw;
  logic [SIDE_W-1:0] sh;
  logic [SIDE_W-1:0] dw;
  logic [SIDE_W-1:0] dh;

  pss_state_t state;
  pss_state_t state_next;

  logic accept;
  logic draw_go;
  logic div_start;
  logic issue;
  logic done_x;
  logic done_y;
  logic [QUO_W-1:0] dx;
  logic [QUO_W-1:0] dy;

  logic [ROW_W-1:0]  row_q;
  logic [PROD_W-1:0] row_prod;
  logic [SIDE_W-1:0] srow;
  logic [BASE_W-1:0] base_prod;
  logic [ADDR_W-1:0] base;
  logic [SIDE_W-1:0] col;
  logic [QUO_W-1:0]  acc;
  logic              col_last;
  logic [ADDR_W-1:0] rd_addr;

  logic               sprite_we;
  logic               palette_we;
  logic [COLOR_W-1:0] sprite_rdata;
  logic [COLOR_W-1:0] pal_rdata;

  logic              s1_valid;
  logic              s1_last;
  logic [SIDE_W-1:0] s1_col;
  logic              s2_valid;
  logic              s2_last;
  logic              s2_we;
  logic [SIDE_W-1:0] s2_col;

  assign sw = clamp_side(src_width);
  assign sh = clamp_side(src_height);
  assign dw = clamp_side(dst_width);
  assign dh = clamp_side(dst_height);

  assign accept  = start && !busy;
  assign draw_go = accept && (cmd.action == ACT_DRAW) && (32'(cmd.row) < 32'(dh));

  assign sprite_we  = accept && (cmd.action == ACT_LOAD_PIXEL) &&
                      (32'(cmd.index) < 32'(DEPTH));
  assign palette_we = accept && (cmd.action == ACT_LOAD_PALETTE) &&
                      (32'(cmd.index) < 32'(PALETTE_SIZE));

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= SIZE_RESET;
      src_height <= SIZE_RESET;
      dst_width  <= SIZE_RESET;
      dst_height <= SIZE_RESET;
      skip_zero  <= 1'b0;
      origin_x   <= '0;
      origin_y   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SRC_WIDTH:  src_width  <= cfg_data[SIZE_W-1:0];
        CFG_SRC_HEIGHT: src_height <= cfg_data[SIZE_W-1:0];
        CFG_DST_WIDTH:  dst_width  <= cfg_data[SIZE_W-1:0];
        CFG_DST_HEIGHT: dst_height <= cfg_data[SIZE_W-1:0];
        CFG_SKIP_ZERO:  skip_zero  <= cfg_data[0];
        CFG_ORIGIN_X:   origin_x   <= cfg_data[ORIGIN_W-1:0];
        CFG_ORIGIN_Y:   origin_y   <= cfg_data[ORIGIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  pss_div #(
    .DVD_W(QUO_W),
    .DVS_W(SIDE_W)
  ) u_div_x (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({sw, FRAC_BITS'(0)}),
    .divisor  (dw),
    .done     (done_x),
    .quotient (dx)
  );

  pss_div #(
    .DVD_W(QUO_W),
    .DVS_W(SIDE_W)
  ) u_div_y (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({sh, FRAC_BITS'(0)}),
    .divisor  (dh),
    .done     (done_y),
    .quotient (dy)
  );

  assign col_last = (col == dw - SIDE_W'(1));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (draw_go) state_next = ST_DIV;
      ST_DIV:   if (done_x && done_y) state_next = ST_SROW;
      ST_SROW:  state_next = ST_BASE;
      ST_BASE:  state_next = ST_RUN;
      ST_RUN:   if (col_last) state_next = ST_DRAIN;
      ST_DRAIN: if (s2_valid && s2_last) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy      = (state != ST_IDLE);
    div_start = (state == ST_IDLE) && draw_go;
    issue     = (state == ST_RUN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      s1_valid    <= 1'b0;
      s2_valid    <= 1'b0;
      pixel_valid <= 1'b0;
    end else begin
      state       <= state_next;
      s1_valid    <= issue;
      s2_valid    <= s1_valid;
      pixel_valid <= s2_valid;
    end
  end

  // source row and row base address, then column accumulator
  assign row_prod  = PROD_W'(row_q) * PROD_W'(dy);
  assign base_prod = BASE_W'(srow) * BASE_W'(sw);
  assign rd_addr   = base + ADDR_W'(acc >> FRAC_BITS);

  always_ff @(posedge clk) begin
    if (div_start) begin
      row_q <= cmd.row;
    end
    if (state == ST_SROW) begin
      srow <= SIDE_W'(row_prod >> FRAC_BITS);
    end
    if (state == ST_BASE) begin
      base <= ADDR_W'(base_prod);
      col  <= '0;
      acc  <= '0;
    end else if (issue) begin
      col <= col + SIDE_W'(1);
      acc <= acc + dx;
    end
  end

  pss_ram #(
    .WIDTH(COLOR_W),
    .DEPTH(DEPTH)
  ) u_sprite_ram (
    .clk   (clk),
    .we    (sprite_we),
    .waddr (ADDR_W'(cmd.index)),
    .wdata (cmd.value),
    .raddr (rd_addr),
    .rdata (sprite_rdata)
  );

  pss_ram #(
    .WIDTH(COLOR_W),
    .DEPTH(PALETTE_SIZE)
  ) u_palette_ram (
    .clk   (clk),
    .we    (palette_we),
    .waddr (cmd.index[PAL_AW-1:0]),
    .wdata (cmd.value),
    .raddr (sprite_rdata),
    .rdata (pal_rdata)
  );

  always_ff @(posedge clk) begin
    s1_col  <= col;
    s1_last <= col_last;
    s2_col  <= s1_col;
    s2_last <= s1_last;
    s2_we   <= !(skip_zero && (sprite_rdata == '0));
    pixel.pixel_x      <= COORD_W'(origin_x) + COORD_W'(s2_col);
    pixel.pixel_y      <= COORD_W'(origin_y) + COORD_W'(row_q);
    pixel.color        <= s2_we ? pal_rdata : '0;
    pixel.write_enable <= s2_we;
    pixel.last         <= s2_last;
  end

endmodule
`default_nettype wire

>>> rtl/pss_checker.sv
// Port-level assertions for the palette sprite scaler, bound to the top level.
`default_nettype none
`include "palette_sprite_scaler_macros.svh"
module pss_checker
  import pss_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input pss_cmd_t   cmd,
  input logic       pixel_valid,
  input pss_pixel_t pixel
);

  `PSS_ASSERT_RST(a_reset_idle, rst |=> !busy && !pixel_valid, "not idle after reset")
  `PSS_ASSERT(a_mid_busy, pixel_valid && !pixel.last |-> busy, "pixel beat outside a draw")
  `PSS_ASSERT(a_last_idle, pixel_valid && pixel.last |-> !busy, "busy after last beat")
  `PSS_ASSERT(a_load_quick, start && !busy && cmd.action != ACT_DRAW |=> !busy, "load held busy")
  `PSS_ASSERT(a_x_step, pixel_valid && !pixel.last |=> pixel_valid && pixel.pixel_x == $past(pixel.pixel_x) + 13'd1, "row beats not contiguous")

endmodule

bind palette_sprite_scaler pss_checker u_pss_checker (.*);
`default_nettype wire

>>> verif/palette_sprite_scaler_tb.sv
// Self-checking testbench for the palette sprite scaler: directed and random beats.
`timescale 1ns / 1ps
module palette_sprite_scaler_tb
  import pss_pkg::*;
();

  localparam int unsigned MAX_SIDE     = 64;
  localparam int unsigned TOTAL_ITEMS  = 470;
  localparam int unsigned PHASE_ITEMS  = 50;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned LIMIT        = 1000000;

  localparam logic [ACTION_W-1:0]  ACT_NONE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NONE = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  pss_cmd_t              cmd = '0;
  logic                  pixel_valid;
  pss_pixel_t            pixel;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  palette_sprite_scaler #(.MAX_SIDE(MAX_SIDE)) DUT (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .pixel_valid(pixel_valid),
    .pixel      (pixel),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #1 clk = ~clk;

  // Register and memory mirror
  logic [SIZE_W-1:0]   m_src_w = SIZE_RESET;
  logic [SIZE_W-1:0]   m_src_h = SIZE_RESET;
  logic [SIZE_W-1:0]   m_dst_w = SIZE_RESET;
  logic [SIZE_W-1:0]   m_dst_h = SIZE_RESET;
  logic                m_skip = 1'b0;
  logic [ORIGIN_W-1:0] m_org_x = '0;
  logic [ORIGIN_W-1:0] m_org_y = '0;
  logic [COLOR_W-1:0]  sprite_mem [MAX_SIDE*MAX_SIDE];
  bit                  sprite_set [MAX_SIDE*MAX_SIDE];
  logic [COLOR_W-1:0]  pal_mem [PALETTE_SIZE];
  bit                  pal_set [PALETTE_SIZE];

  pss_pixel_t  pending_pixels [$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned idle_pct = 0;
  int unsigned items_sent = 0;

  function automatic int unsigned side(logic [SIZE_W-1:0] v);
    if (v == '0) return 1;
    if (32'(v) > MAX_SIDE) return MAX_SIDE;
    return 32'(v);
  endfunction

  function automatic int unsigned src_addr(int unsigned row, int unsigned col);
    int unsigned sw, dx, dy;
    sw = side(m_src_w);
    dx = (sw << FRAC_BITS) / side(m_dst_w);
    dy = (side(m_src_h) << FRAC_BITS) / side(m_dst_h);
    return ((row * dy) >> FRAC_BITS) * sw + ((col * dx) >> FRAC_BITS);
  endfunction

  function automatic pss_cmd_t mk_cmd(logic [ACTION_W-1:0] a, logic [INDEX_W-1:0] i,
                                      logic [COLOR_W-1:0] v, logic [ROW_W-1:0] r);
    pss_cmd_t c;
    c.action = a;
    c.index  = i;
    c.value  = v;
    c.row    = r;
    return c;
  endfunction

  // Half the time a low color (0 to 7) so zeros and palette reuse are common.
  function automatic logic [COLOR_W-1:0] pick_color();
    return ($urandom_range(1) != 0) ? COLOR_W'($urandom_range(255))
                                    : COLOR_W'($urandom_range(7));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_size();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return CFG_DATA_W'($urandom_range(1, 12));
    if (r < 85) return CFG_DATA_W'($urandom_range(13, 64));
    return CFG_DATA_W'($urandom_range(4095));
  endfunction

  // Applies one accepted beat to the mirror and queues the pixels of a draw.
  task automatic scale_cmd(input pss_cmd_t c);
    int unsigned dw, col;
    logic [COLOR_W-1:0] pix;
    pss_pixel_t p;
    case (c.action)
      ACT_LOAD_PIXEL: begin
        if (32'(c.index) < MAX_SIDE * MAX_SIDE) begin
          sprite_mem[c.index] = c.value;
          sprite_set[c.index] = 1'b1;
        end
      end
      ACT_LOAD_PALETTE: begin
        if (32'(c.index) < PALETTE_SIZE) begin
          pal_mem[c.index[PAL_AW-1:0]] = c.value;
          pal_set[c.index[PAL_AW-1:0]] = 1'b1;
        end
      end
      ACT_DRAW: begin
        dw = side(m_dst_w);
        if (32'(c.row) < side(m_dst_h)) begin
          for (col = 0; col < dw; col++) begin
            pix = sprite_mem[src_addr(32'(c.row), col)];
            p.pixel_x      = COORD_W'(32'(m_org_x) + col);
            p.pixel_y      = COORD_W'(32'(m_org_y) + 32'(c.row));
            p.write_enable = !(m_skip && pix == '0);
            p.color        = p.write_enable ? pal_mem[pix] : '0;
            p.last         = (col + 1 == dw);
            pending_pixels.push_back(p);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_cmd(input pss_cmd_t c);
    int unsigned gap;
    start <= 1'b1;
    cmd   <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    scale_cmd(c);
    items_sent++;
    if ($urandom_range(99) < idle_pct) begin
      gap = ($urandom_range(3) == 0) ? $urandom_range(1, 100) : $urandom_range(1, 4);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      CFG_SRC_WIDTH:  m_src_w = data[SIZE_W-1:0];
      CFG_SRC_HEIGHT: m_src_h = data[SIZE_W-1:0];
      CFG_DST_WIDTH:  m_dst_w = data[SIZE_W-1:0];
      CFG_DST_HEIGHT: m_dst_h = data[SIZE_W-1:0];
      CFG_SKIP_ZERO:  m_skip  = data[0];
      CFG_ORIGIN_X:   m_org_x = data[ORIGIN_W-1:0];
      CFG_ORIGIN_Y:   m_org_y = data[ORIGIN_W-1:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_geometry(input int unsigned sw, input int unsigned sh,
                              input int unsigned dw, input int unsigned dh);
    write_reg(CFG_SRC_WIDTH, CFG_DATA_W'(sw));
    write_reg(CFG_SRC_HEIGHT, CFG_DATA_W'(sh));
    write_reg(CFG_DST_WIDTH, CFG_DATA_W'(dw));
    write_reg(CFG_DST_HEIGHT, CFG_DATA_W'(dh));
  endtask

  // Loads every sprite and palette entry that a draw of this row will read.
  task automatic prime_row(input int unsigned row);
    int unsigned dw, col, a;
    logic [COLOR_W-1:0] pix;
    dw = side(m_dst_w);
    for (col = 0; col < dw; col++) begin
      a = src_addr(row, col);
      if (!sprite_set[a])
        send_cmd(mk_cmd(ACT_LOAD_PIXEL, INDEX_W'(a), pick_color(),
                        ROW_W'($urandom_range(63))));
    end
    for (col = 0; col < dw; col++) begin
      pix = sprite_mem[src_addr(row, col)];
      if (!pal_set[pix] && !(m_skip && pix == '0))
        send_cmd(mk_cmd(ACT_LOAD_PALETTE, INDEX_W'(pix), COLOR_W'($urandom_range(255)),
                        ROW_W'($urandom_range(63))));
    end
  endtask

  task automatic draw_row(input int unsigned row);
    prime_row(row);
    send_cmd(mk_cmd(ACT_DRAW, INDEX_W'($urandom_range(4095)), COLOR_W'($urandom_range(255)),
                    ROW_W'(row)));
  endtask

  task automatic test_default_sizes();
    draw_row(63);
    draw_row(0);
  endtask

  task automatic test_size_extremes();
    set_geometry(1, 1, 1, 1);
    draw_row(0);
    set_geometry(64, 64, 1, 2);
    draw_row(1);
    // zero acts as one, oversize values clamp to the maximum side
    set_geometry(0, 1, 'hFFF, 65);
    write_reg(CFG_ORIGIN_X, 12'hFFF);
    write_reg(CFG_ORIGIN_Y, 12'hFFF);
    draw_row(63);
    draw_row(0);
  endtask

  task automatic test_skip_zero();
    set_geometry(4, 4, 4, 4);
    write_reg(CFG_SKIP_ZERO, 12'hFFF);
    send_cmd(mk_cmd(ACT_LOAD_PIXEL, 12'd0, 8'd0, 6'd0));
    send_cmd(mk_cmd(ACT_LOAD_PIXEL, 12'd1, 8'd5, 6'd63));
    send_cmd(mk_cmd(ACT_LOAD_PIXEL, 12'd2, 8'd0, 6'd21));
    send_cmd(mk_cmd(ACT_LOAD_PIXEL, 12'd3, 8'd255, 6'd42));
    draw_row(0);
    write_reg(CFG_SKIP_ZERO, 12'hFFE);
    draw_row(0);
  endtask

  task automatic test_row_past_height();
    set_geometry(3, 5, 7, 4);
    send_cmd(mk_cmd(ACT_DRAW, 12'hFFF, 8'hFF, 6'd4));
    send_cmd(mk_cmd(ACT_DRAW, 12'h000, 8'h00, 6'd63));
    draw_row(3);
  endtask

  task automatic test_ignored_inputs();
    set_geometry(1, 1, 1, 1);
    write_reg(CFG_SKIP_ZERO, 12'h000);
    write_reg(CFG_ORIGIN_X, 12'h000);
    write_reg(CFG_ORIGIN_Y, 12'h000);
    send_cmd(mk_cmd(ACT_LOAD_PIXEL, 12'd0, 8'd0, 6'd0));
    send_cmd(mk_cmd(ACT_LOAD_PALETTE, 12'd0, 8'h3C, 6'd0));
    // out-of-range palette indexes are dropped; they would alias entry 0 if truncated
    send_cmd(mk_cmd(ACT_LOAD_PALETTE, 12'h100, 8'hA5, 6'd0));
    send_cmd(mk_cmd(ACT_LOAD_PALETTE, 12'hF00, 8'h5A, 6'd63));
    send_cmd(mk_cmd(ACT_NONE, 12'hFFF, 8'hFF, 6'd63));
    send_cmd(mk_cmd(ACT_NONE, 12'h000, 8'h00, 6'd0));
    write_reg(CFG_NONE, 12'hFFF);
    draw_row(0);
  endtask

  task automatic randomize_regs();
    int unsigned r;
    logic [CFG_DATA_W-1:0] v;
    write_reg(CFG_SRC_WIDTH, pick_size());
    write_reg(CFG_SRC_HEIGHT, pick_size());
    write_reg(CFG_DST_WIDTH, pick_size());
    write_reg(CFG_DST_HEIGHT, pick_size());
    write_reg(CFG_SKIP_ZERO, CFG_DATA_W'($urandom_range(4095)));
    r = $urandom_range(99);
    v = (r < 20) ? 12'h000 : (r < 40) ? 12'hFFF : CFG_DATA_W'($urandom_range(4095));
    write_reg(CFG_ORIGIN_X, v);
    r = $urandom_range(99);
    v = (r < 20) ? 12'h000 : (r < 40) ? 12'hFFF : CFG_DATA_W'($urandom_range(4095));
    write_reg(CFG_ORIGIN_Y, v);
    if ($urandom_range(3) == 0) write_reg(CFG_NONE, CFG_DATA_W'($urandom_range(4095)));
  endtask

  task automatic test_random();
    int unsigned phase, phase_end, r, dh;
    phase = 0;
    while (items_sent < TOTAL_ITEMS) begin
      randomize_regs();
      if (phase % 3 == 0) idle_pct = 0;
      else if (phase % 3 == 1) idle_pct = 84;
      else idle_pct = 14;
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end && items_sent < TOTAL_ITEMS) begin
        r = $urandom_range(99);
        dh = side(m_dst_h);
        if (r < 50) begin
          draw_row($urandom_range(dh - 1));
        end else if (r < 70) begin
          send_cmd(mk_cmd(ACT_LOAD_PIXEL, INDEX_W'($urandom_range(4095)), pick_color(),
                          ROW_W'($urandom_range(63))));
        end else if (r < 85) begin
          send_cmd(mk_cmd(ACT_LOAD_PALETTE, INDEX_W'($urandom_range(255)),
                          COLOR_W'($urandom_range(255)), ROW_W'($urandom_range(63))));
        end else if (r < 90 && dh < MAX_SIDE) begin
          send_cmd(mk_cmd(ACT_DRAW, INDEX_W'($urandom_range(4095)),
                          COLOR_W'($urandom_range(255)), ROW_W'($urandom_range(dh, 63))));
        end else if (r < 95) begin
          send_cmd(mk_cmd(ACT_LOAD_PALETTE, INDEX_W'($urandom_range(256, 4095)),
                          COLOR_W'($urandom_range(255)), ROW_W'($urandom_range(63))));
        end else begin
          send_cmd(mk_cmd(ACT_NONE, INDEX_W'($urandom_range(4095)),
                          COLOR_W'($urandom_range(255)), ROW_W'($urandom_range(63))));
        end
      end
      phase++;
    end
    idle_pct = 0;
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(posedge clk) begin : check_pixels
    pss_pixel_t want;
    if (!rst && pixel_valid) begin
      if (pending_pixels.size() == 0) begin
        errors++;
        $error("unexpected pixel x=%0d y=%0d", pixel.pixel_x, pixel.pixel_y);
      end else begin
        want = pending_pixels.pop_front();
        check_field("pixel_x", 32'(want.pixel_x), 32'(pixel.pixel_x));
        check_field("pixel_y", 32'(want.pixel_y), 32'(pixel.pixel_y));
        check_field("color", 32'(want.color), 32'(pixel.color));
        check_field("write_enable", 32'(want.write_enable), 32'(pixel.write_enable));
        check_field("last", 32'(want.last), 32'(pixel.last));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("palette_sprite_scaler_tb failed");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_sizes();
    test_size_extremes();
    test_skip_zero();
    test_row_past_height();
    test_ignored_inputs();
    test_random();
    wait_idle();
    if (errors == 0) begin
      $display("palette_sprite_scaler_tb passed");
    end else begin
      $display("palette_sprite_scaler_tb failed");
    end
    $finish;
  end

endmodule
